// File: rtl/bdlp_pkg.sv
// shared types, widths and constants of the button debounce / long-press encoder block
`timescale 1ns / 1ps

package bdlp_pkg;

    localparam int TIME_W = 32;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
    localparam logic [IDX_W-1:0] REG_LONG_PRESS = 1'b1;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

    typedef struct packed {
        logic                    main_level;
        logic                    ping_level;
        logic signed [POS_W-1:0] encoder_position;
        logic [TIME_W-1:0]       now_ms;
    } t_in_item;

    typedef struct packed {
        logic                    main_click;
        logic                    main_long;
        logic                    ping_press;
        logic                    rotated;
        logic                    pushed_rotated;
        logic signed [POS_W-1:0] position;
    } t_out_item;

endpackage

// File: rtl/bdlp_if.sv
// input and output channel interfaces of the button debounce / long-press encoder block
`timescale 1ns / 1ps

interface bdlp_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 main_level;
    logic                                 ping_level;
    logic signed [bdlp_pkg::POS_W-1:0]    encoder_position;
    logic [bdlp_pkg::TIME_W-1:0]          now_ms;

    modport source (output valid, main_level, ping_level, encoder_position, now_ms,
                    input ready);
    modport sink (input valid, main_level, ping_level, encoder_position, now_ms,
                  output ready);
endinterface

interface bdlp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 main_click;
    logic                                 main_long;
    logic                                 ping_press;
    logic                                 rotated;
    logic                                 pushed_rotated;
    logic signed [bdlp_pkg::POS_W-1:0]    position;

    modport source (output valid, main_click, main_long, ping_press, rotated,
                    pushed_rotated, position, input ready);
    modport sink (input valid, main_click, main_long, ping_press, rotated,
                  pushed_rotated, position, output ready);
endinterface

// File: rtl/bdlp_core.sv
// debounce state, long-press tracking and encoder change detection for one poll
`timescale 1ns / 1ps

module bdlp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  bdlp_pkg::t_cfg      i_cfg,
    input  bdlp_pkg::t_in_item  i_item,
    output bdlp_pkg::t_out_item o_result
);

    logic                          r_main_stable, n_main_stable;
    logic [bdlp_pkg::TIME_W-1:0]   r_main_changed_at, n_main_changed_at;
    logic                          r_long_seen, n_long_seen;
    logic                          r_ping_stable, n_ping_stable;
    logic [bdlp_pkg::TIME_W-1:0]   r_ping_changed_at, n_ping_changed_at;
    logic [bdlp_pkg::POS_W-1:0]    r_last_position, n_last_position;

    logic [bdlp_pkg::TIME_W-1:0]   main_elapsed;
    logic [bdlp_pkg::TIME_W-1:0]   ping_elapsed;
    logic                          long_hit;
    logic                          long_after_test;
    logic                          main_accept;
    logic                          ping_accept;
    logic                          pos_changed;

    always_comb begin
        main_elapsed = i_item.now_ms - r_main_changed_at;
        ping_elapsed = i_item.now_ms - r_ping_changed_at;

        // long press test sees the stable level from before this poll
        long_hit = !r_long_seen && !r_main_stable &&
                   (main_elapsed > {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}},
                                    i_cfg.long_press_ms});
        long_after_test = r_long_seen | long_hit;

        main_accept = (i_item.main_level != r_main_stable) &&
                      (main_elapsed > {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}},
                                       i_cfg.debounce_ms});
        ping_accept = (i_item.ping_level != r_ping_stable) &&
                      (ping_elapsed > {{(bdlp_pkg::TIME_W-bdlp_pkg::CFG_W){1'b0}},
                                       i_cfg.debounce_ms});

        n_main_stable     = main_accept ? i_item.main_level : r_main_stable;
        n_main_changed_at = main_accept ? i_item.now_ms : r_main_changed_at;
        n_ping_stable     = ping_accept ? i_item.ping_level : r_ping_stable;
        n_ping_changed_at = ping_accept ? i_item.now_ms : r_ping_changed_at;

        pos_changed     = i_item.encoder_position != r_last_position;
        n_last_position = pos_changed ? i_item.encoder_position : r_last_position;

        // release clears the hold flag; a rotation during a hold sets it
        if (pos_changed && !n_main_stable) begin
            n_long_seen = 1'b1;
        end else if (main_accept && i_item.main_level) begin
            n_long_seen = 1'b0;
        end else begin
            n_long_seen = long_after_test;
        end

        o_result.main_click     = main_accept && i_item.main_level && !long_after_test;
        o_result.main_long      = long_hit;
        o_result.ping_press     = ping_accept && !i_item.ping_level;
        o_result.rotated        = pos_changed && n_main_stable;
        o_result.pushed_rotated = pos_changed && !n_main_stable;
        o_result.position       = pos_changed ? i_item.encoder_position : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_stable     <= 1'b1;
            r_main_changed_at <= '0;
            r_long_seen       <= 1'b0;
            r_ping_stable     <= 1'b1;
            r_ping_changed_at <= '0;
            r_last_position   <= '0;
        end else if (i_step) begin
            r_main_stable     <= n_main_stable;
            r_main_changed_at <= n_main_changed_at;
            r_long_seen       <= n_long_seen;
            r_ping_stable     <= n_ping_stable;
            r_ping_changed_at <= n_ping_changed_at;
            r_last_position   <= n_last_position;
        end
    end

endmodule

// File: rtl/button_debounce_long_press_encoder_top.sv
// top level of the button debounce / long-press encoder block
`timescale 1ns / 1ps

// polls arrive on i_in: both active-low button levels, the encoder count and a
// millisecond timestamp; every poll gives exactly one result transaction on o_out
// with click, long press, second-button press, rotation and pushed-rotation flags
// plus the encoder position (zero when no rotation is flagged)
// debounce_ms and long_press_ms are written through i_cfg_we / i_cfg_index /
// i_cfg_data while the block is idle, a rule on the user that the block itself
// does not enforce; data is 16 bits wide; an accepted poll goes through the
// input register, then one pass of debounce logic into the result register
// throughput: one poll per clock while o_out.ready holds; the single pass of
// debounce logic with its 32-bit elapsed-time subtract and compare sets the cycle
// reset (synchronous, active low) empties both registers, sets both buttons to
// released, clears time stamps, hold flag and last position, and restores the
// register defaults of 50 ms and 1000 ms
// a stalled receiver holds the result register; the input register still takes
// one more poll, then i_in.ready drops until the result is taken
module button_debounce_long_press_encoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bdlp_in_if.sink                       i_in,
    bdlp_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [bdlp_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bdlp_pkg::CFG_W-1:0]    i_cfg_data
);

    // configuration registers
    bdlp_pkg::t_cfg      r_cfg;

    // input register stage
    logic                r_in_valid;
    bdlp_pkg::t_in_item  r_in_item;

    // result register stage
    logic                r_out_valid;
    bdlp_pkg::t_out_item r_out_item;

    bdlp_pkg::t_out_item result;
    logic                out_free;
    logic                step;
    logic                in_take;

    // result register can load when empty or being drained this cycle
    assign out_free = !r_out_valid || o_out.ready;
    assign step     = r_in_valid && out_free;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bdlp_pkg::DEBOUNCE_RST;
            r_cfg.long_press_ms <= bdlp_pkg::LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bdlp_pkg::REG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                bdlp_pkg::REG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.main_level       <= i_in.main_level;
            r_in_item.ping_level       <= i_in.ping_level;
            r_in_item.encoder_position <= i_in.encoder_position;
            r_in_item.now_ms           <= i_in.now_ms;
        end
    end

    bdlp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.main_click     = r_out_item.main_click;
    assign o_out.main_long      = r_out_item.main_long;
    assign o_out.ping_press     = r_out_item.ping_press;
    assign o_out.rotated        = r_out_item.rotated;
    assign o_out.pushed_rotated = r_out_item.pushed_rotated;
    assign o_out.position       = r_out_item.position;

    // a rotation is either plain or pushed, never both
    a_rot_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.rotated && r_out_item.pushed_rotated))
        else $error("rotated and pushed_rotated both set");

    // position is only reported alongside a rotation
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.rotated && !r_out_item.pushed_rotated)
            |-> (r_out_item.position == '0))
        else $error("position nonzero without rotation");

    // the poll that flags a long press can never also give a click
    a_click_vs_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.main_click && r_out_item.main_long))
        else $error("click and long press in one result");

    // a result appears only after the input stage held a poll
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_in_valid))
        else $error("result without a poll in the input stage");

endmodule

// File: bench/tb_button_debounce_long_press_encoder_top.sv
// self-checking testbench for the button debounce / long-press encoder top level
`timescale 1ns / 1ps

module tb_button_debounce_long_press_encoder_top;

    // flag patterns of a result, in struct order: click, long, ping, rotated, pushed
    localparam logic [4:0] EV_NONE     = 5'b00000;
    localparam logic [4:0] EV_CLICK    = 5'b10000;
    localparam logic [4:0] EV_LONG     = 5'b01000;
    localparam logic [4:0] EV_PING     = 5'b00100;
    localparam logic [4:0] EV_ROT      = 5'b00010;
    localparam logic [4:0] EV_PUSH_ROT = 5'b00001;

    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_POLLS   = 110;
    localparam int SETTLE_CYCLES = 4;

    // one directed poll; typed rows carry their result, the rest go through the predictor
    typedef struct packed {
        logic                        main_level;
        logic                        ping_level;
        logic [bdlp_pkg::POS_W-1:0]  count;
        logic [bdlp_pkg::TIME_W-1:0] stamp;
        logic                        typed;
        logic [4:0]                  flags;
        logic [bdlp_pkg::POS_W-1:0]  where;
    } t_poll_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [bdlp_pkg::IDX_W-1:0]    i_cfg_index;
    logic [bdlp_pkg::CFG_W-1:0]    i_cfg_data;

    bdlp_in_if  poll_ch ();
    bdlp_out_if event_ch ();

    button_debounce_long_press_encoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (poll_ch),
        .o_out       (event_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of the registers and of the debounce state
    logic [bdlp_pkg::CFG_W-1:0]        debounce_ms_q;
    logic [bdlp_pkg::CFG_W-1:0]        long_press_ms_q;
    logic                              main_up;
    logic [bdlp_pkg::TIME_W-1:0]       main_edge_ms;
    logic                              long_flagged;
    logic                              ping_up;
    logic [bdlp_pkg::TIME_W-1:0]       ping_edge_ms;
    logic signed [bdlp_pkg::POS_W-1:0] last_count;

    // button events still owed by the block, oldest first
    bdlp_pkg::t_out_item awaited_events [$];
    int                  mismatch_count;
    bit                  steady_traffic;

    // stimulus cursor: pin levels, knob count and clock of the simulated user
    logic [bdlp_pkg::TIME_W-1:0]       sweep_ms;
    logic                              main_pin;
    logic                              ping_pin;
    logic signed [bdlp_pkg::POS_W-1:0] knob_count;

    t_poll_row poll_table [DIRECTED_ROWS] = '{
        // idle right after reset, then a press exactly at the debounce time is refused
        {1'b1, 1'b1, 32'h0000_0000, 32'd0,    1'b1, EV_NONE,  32'h0},
        {1'b0, 1'b1, 32'h0000_0000, 32'd50,   1'b1, EV_NONE,  32'h0},
        // both buttons pressed one ms later, then a bounce inside the debounce window
        {1'b0, 1'b0, 32'h0000_0000, 32'd51,   1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'h0000_0000, 32'd100,  1'b0, EV_NONE,  32'h0},
        // hold reaches the long-press time, then passes it by one ms
        {1'b0, 1'b0, 32'h0000_0000, 32'd1051, 1'b0, EV_NONE,  32'h0},
        {1'b0, 1'b0, 32'h0000_0000, 32'd1052, 1'b1, EV_LONG,  32'h0},
        // release after a long press gives no click
        {1'b1, 1'b1, 32'h0000_0000, 32'd1060, 1'b0, EV_NONE,  32'h0},
        // short press and release: click
        {1'b0, 1'b1, 32'h0000_0000, 32'd1200, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'h0000_0000, 32'd1300, 1'b1, EV_CLICK, 32'h0},
        // rotation to both ends of the count range
        {1'b1, 1'b1, 32'h7FFF_FFFF, 32'd1301, 1'b1, EV_ROT,   32'h7FFF_FFFF},
        {1'b1, 1'b1, 32'h8000_0000, 32'd1302, 1'b1, EV_ROT,   32'h8000_0000},
        // rotation while held marks the hold long, so the release is silent
        {1'b0, 1'b1, 32'h8000_0000, 32'd1400, 1'b0, EV_NONE,  32'h0},
        {1'b0, 1'b1, 32'hFFFF_FFFF, 32'd1401, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1500, 1'b0, EV_NONE,  32'h0},
        // press at the top of the ms range, long press measured across the wrap
        {1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, EV_NONE, 32'h0},
        {1'b0, 1'b1, 32'hFFFF_FFFF, 32'd999,  1'b0, EV_NONE,  32'h0},
        {1'b0, 1'b1, 32'hFFFF_FFFF, 32'd1000, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1001, 1'b0, EV_NONE,  32'h0},
        // long press and accepted release in the same poll
        {1'b0, 1'b1, 32'hFFFF_FFFF, 32'd2000, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'hFFFF_FFFF, 32'd3001, 1'b0, EV_NONE,  32'h0},
        // second button: press, bounce refused at the boundary, release accepted
        {1'b1, 1'b0, 32'hFFFF_FFFF, 32'd3002, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'hFFFF_FFFF, 32'd3052, 1'b0, EV_NONE,  32'h0},
        {1'b1, 1'b1, 32'hFFFF_FFFF, 32'd3053, 1'b0, EV_NONE,  32'h0},
        // rotation back to zero still reports, then a repeat poll at the same ms
        {1'b1, 1'b1, 32'h0000_0000, 32'd3054, 1'b1, EV_ROT,   32'h0},
        {1'b1, 1'b1, 32'h0000_0000, 32'd3054, 1'b0, EV_NONE,  32'h0}
    };

    // one poll through the debounce logic, updating the predictor state
    function automatic bdlp_pkg::t_out_item debounce_poll(input bdlp_pkg::t_in_item poll);
        bdlp_pkg::t_out_item         res;
        logic [bdlp_pkg::TIME_W-1:0] main_age;
        logic [bdlp_pkg::TIME_W-1:0] ping_age;
        res      = '0;
        main_age = poll.now_ms - main_edge_ms;
        ping_age = poll.now_ms - ping_edge_ms;
        // long-press test sees the level and stamp from before this poll
        if (!long_flagged && !main_up && main_age > long_press_ms_q) begin
            long_flagged  = 1'b1;
            res.main_long = 1'b1;
        end
        if (poll.main_level != main_up && main_age > debounce_ms_q) begin
            if (poll.main_level) begin
                if (!long_flagged)
                    res.main_click = 1'b1;
                else
                    long_flagged = 1'b0;
            end
            main_up      = poll.main_level;
            main_edge_ms = poll.now_ms;
        end
        if (poll.ping_level != ping_up && ping_age > debounce_ms_q) begin
            res.ping_press = !poll.ping_level;
            ping_up        = poll.ping_level;
            ping_edge_ms   = poll.now_ms;
        end
        if (poll.encoder_position != last_count) begin
            if (!main_up) begin
                long_flagged       = 1'b1;
                res.pushed_rotated = 1'b1;
            end else begin
                res.rotated = 1'b1;
            end
            res.position = poll.encoder_position;
            last_count   = poll.encoder_position;
        end
        return res;
    endfunction

    // next poll of a user pressing, holding and turning; a few polls are pure noise
    function automatic bdlp_pkg::t_in_item next_poll();
        bdlp_pkg::t_in_item          poll;
        logic [bdlp_pkg::TIME_W-1:0] aim;
        int unsigned                 pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            poll.main_level       = 1'($urandom);
            poll.ping_level       = 1'($urandom);
            poll.encoder_position = $urandom;
            poll.now_ms           = $urandom;
            return poll;
        end
        // time step: mostly bounce-sized, some aimed right at a threshold
        if (pick <= 7)
            aim = sweep_ms + $urandom_range(0, 3);
        else if (pick <= 12)
            aim = sweep_ms + $urandom_range(0, 2 * int'(debounce_ms_q) + 2);
        else if (pick <= 14)
            aim = main_edge_ms + debounce_ms_q + $urandom_range(0, 1);
        else if (pick == 15)
            aim = ping_edge_ms + debounce_ms_q + $urandom_range(0, 1);
        else if (pick <= 17)
            aim = main_edge_ms + long_press_ms_q + $urandom_range(0, 1);
        else if (pick == 18)
            aim = sweep_ms + $urandom_range(0, 2 * int'(long_press_ms_q) + 2);
        else
            aim = sweep_ms + $urandom;
        // aimed stamps only move the clock forward; the wild jump may wrap it
        if (pick == 19 || aim - sweep_ms < 32'h8000_0000)
            sweep_ms = aim;
        if ($urandom_range(0, 3) == 0)
            main_pin = !main_pin;
        if ($urandom_range(0, 3) == 0)
            ping_pin = !ping_pin;
        case ($urandom_range(0, 9))
            6, 7: knob_count = knob_count + $urandom_range(1, 3);
            8: knob_count = knob_count - $urandom_range(1, 3);
            9: knob_count = $urandom;
            default: ;
        endcase
        poll.main_level       = main_pin;
        poll.ping_level       = ping_pin;
        poll.encoder_position = knob_count;
        poll.now_ms           = sweep_ms;
        return poll;
    endfunction

    // offer one poll from a falling edge, record the owed events once it is taken
    task automatic send_poll(input bdlp_pkg::t_in_item poll, input bit typed,
                             input bdlp_pkg::t_out_item typed_result);
        bdlp_pkg::t_out_item predicted;
        if (!steady_traffic && $urandom_range(0, 11) == 0) begin
            poll_ch.valid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        poll_ch.valid            = 1'b1;
        poll_ch.main_level       = poll.main_level;
        poll_ch.ping_level       = poll.ping_level;
        poll_ch.encoder_position = poll.encoder_position;
        poll_ch.now_ms           = poll.now_ms;
        do
            @(posedge i_clk);
        while (poll_ch.ready !== 1'b1);
        // predictor always steps, so later rows see the right state
        predicted = debounce_poll(poll);
        awaited_events.push_back(typed ? typed_result : predicted);
    endtask

    task automatic run_random(input int polls);
        for (int k = 0; k < polls; k++) begin
            @(negedge i_clk);
            send_poll(next_poll(), 1'b0, '0);
        end
        @(negedge i_clk);
        poll_ch.valid = 1'b0;
    endtask

    // hold the sender until every owed event is back, then let the block settle
    task automatic drain_events();
        while (awaited_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bdlp_pkg::IDX_W-1:0] reg_sel,
                             input logic [bdlp_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = reg_sel;
        i_cfg_data  = value;
        if (reg_sel == bdlp_pkg::REG_DEBOUNCE)
            debounce_ms_q = value;
        else
            long_press_ms_q = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: ready drops in bursts until the quiet tail of the run
    initial begin
        int stall_left;
        stall_left     = 0;
        event_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_traffic || !i_rst_n) begin
                event_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                event_ch.ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 15) == 0) begin
                event_ch.ready = 1'b0;
                stall_left     = $urandom_range(1, 13) - 1;
            end else begin
                event_ch.ready = 1'b1;
            end
        end
    end

    // every result transaction is matched against the oldest owed events
    always @(posedge i_clk) begin
        bdlp_pkg::t_out_item want;
        if (i_rst_n && event_ch.valid === 1'b1 && event_ch.ready === 1'b1) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: result transaction with no events owed, expected none, actual %0h",
                         $time, event_ch.position);
                mismatch_count++;
            end else begin
                want = awaited_events.pop_front();
                check_field("main_click", 32'(want.main_click), 32'(event_ch.main_click));
                check_field("main_long", 32'(want.main_long), 32'(event_ch.main_long));
                check_field("ping_press", 32'(want.ping_press), 32'(event_ch.ping_press));
                check_field("rotated", 32'(want.rotated), 32'(event_ch.rotated));
                check_field("pushed_rotated", 32'(want.pushed_rotated),
                            32'(event_ch.pushed_rotated));
                check_field("position", want.position, event_ch.position);
            end
        end
    end

    initial begin
        bdlp_pkg::t_in_item poll;
        t_poll_row          row;
        i_rst_n                  = 1'b0;
        i_cfg_we                 = 1'b0;
        i_cfg_index              = bdlp_pkg::REG_DEBOUNCE;
        i_cfg_data               = '0;
        poll_ch.valid            = 1'b0;
        poll_ch.main_level       = 1'b1;
        poll_ch.ping_level       = 1'b1;
        poll_ch.encoder_position = '0;
        poll_ch.now_ms           = '0;
        steady_traffic           = 1'b0;
        mismatch_count           = 0;
        // predictor starts from the reset state
        debounce_ms_q   = bdlp_pkg::DEBOUNCE_RST;
        long_press_ms_q = bdlp_pkg::LONG_PRESS_RST;
        main_up         = 1'b1;
        main_edge_ms    = '0;
        long_flagged    = 1'b0;
        ping_up         = 1'b1;
        ping_edge_ms    = '0;
        last_count      = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows at the reset register values
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            @(negedge i_clk);
            row                   = poll_table[r];
            poll.main_level       = row.main_level;
            poll.ping_level       = row.ping_level;
            poll.encoder_position = row.count;
            poll.now_ms           = row.stamp;
            send_poll(poll, row.typed, bdlp_pkg::t_out_item'({row.flags, row.where}));
        end

        // random user traffic continuing from the directed state
        sweep_ms   = 32'd3054;
        main_pin   = 1'b1;
        ping_pin   = 1'b1;
        knob_count = '0;
        run_random(PHASE_POLLS);

        // lowest settings: any later ms counts as past debounce and long press
        drain_events();
        write_reg(bdlp_pkg::REG_DEBOUNCE, '0);
        write_reg(bdlp_pkg::REG_LONG_PRESS, '0);
        run_random(PHASE_POLLS);

        // highest settings: only aimed, long or wild time steps get through
        drain_events();
        write_reg(bdlp_pkg::REG_DEBOUNCE, 16'hFFFF);
        write_reg(bdlp_pkg::REG_LONG_PRESS, 16'hFFFF);
        run_random(PHASE_POLLS);

        drain_events();
        write_reg(bdlp_pkg::REG_DEBOUNCE, 16'($urandom_range(1, 30)));
        write_reg(bdlp_pkg::REG_LONG_PRESS, 16'($urandom_range(1, 300)));
        run_random(PHASE_POLLS);

        // closing stretch at full rate on both sides
        drain_events();
        write_reg(bdlp_pkg::REG_DEBOUNCE, 16'd2);
        write_reg(bdlp_pkg::REG_LONG_PRESS, 16'd20);
        steady_traffic = 1'b1;
        run_random(PHASE_POLLS);

        drain_events();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
